// ===== sv/eavr_pkg.sv =====
// ----------------------------------------------------------------------------
// eavr_pkg
// shared constants and the cordic arctangent table for the euler rotation unit
// ----------------------------------------------------------------------------
package eavr_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int DATA_BITS_DEF  = 32;
  localparam int TRIG_ITER_DEF  = 16;
  localparam int ATAN_COUNT     = 24;
  localparam int TW             = 34;   // cordic x/y/z width
  localparam int QW             = 33;   // q2.30 coefficient width (m entries up to ~2)

  localparam logic signed [TW-1:0] CORDIC_K = TW'(652032874);

  function automatic logic signed [TW-1:0] atan_turn(input int i);
    logic signed [TW-1:0] r;
    begin
      case (i)
        0:  r = TW'(536870912);
        1:  r = TW'(316933406);
        2:  r = TW'(167458907);
        3:  r = TW'(85268948);
        4:  r = TW'(42667331);
        5:  r = TW'(21354465);
        6:  r = TW'(10680862);
        7:  r = TW'(5340245);
        8:  r = TW'(2670163);
        9:  r = TW'(1335087);
        10: r = TW'(667544);
        11: r = TW'(333772);
        12: r = TW'(166886);
        13: r = TW'(83443);
        14: r = TW'(41722);
        15: r = TW'(20861);
        16: r = TW'(10430);
        17: r = TW'(5215);
        18: r = TW'(2608);
        19: r = TW'(1304);
        20: r = TW'(652);
        21: r = TW'(326);
        22: r = TW'(163);
        default: r = TW'(81);
      endcase
      return r;
    end
  endfunction

  // rounded q2.30 product: floor((a*b + 2^29) / 2^30)
  function automatic logic signed [QW-1:0] mulq(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    begin
      p = a * b + (2*QW)'(64'sd536870912);
      return QW'(p >>> 30);
    end
  endfunction

endpackage

// ===== sv/euler_angle_vector_rotation_unit.sv =====
// ----------------------------------------------------------------------------
// euler_angle_vector_rotation_unit
// an input beat passes the load stage, the cordic stages, then the quadrant map,
// first product, matrix, product and sum stages (cordic steps are capped at 24)
// throughput: one beat per cycle; a stall freezes the whole pipeline
// reset: rst_n synchronous active low clears the stage valid bits only
// trig by a pipelined cordic (one stage per step), then matrix and dot products
// ----------------------------------------------------------------------------
module euler_angle_vector_rotation_unit
  import eavr_pkg::*;
#(
  parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
  parameter int DATA_BITS       = DATA_BITS_DEF,
  parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // command, vec_x, vec_y, vec_z, pitch_angle, yaw_angle, roll_angle
  input  logic [((1+3*DATA_BITS+3*ANGLE_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // out_x, out_y, out_z
  output logic [((3*DATA_BITS+7)/8)*8-1:0] out_tdata
);

  localparam int NIT = (TRIG_ITERATIONS > ATAN_COUNT) ? ATAN_COUNT : TRIG_ITERATIONS;
  localparam int PW  = QW + DATA_BITS;          // product width
  localparam int SW  = PW + 2;                  // sum of three
  localparam int OW  = ((3*DATA_BITS+7)/8)*8;
  localparam logic signed [SW-1:0] SAT_MAX = SW'({1'b0, {(DATA_BITS-1){1'b1}}});
  localparam logic signed [SW-1:0] SAT_MIN = ~SAT_MAX;

  logic adv;
  assign adv = out_tready | ~out_tvalid;
  assign in_tready = adv;

  // ---------------- input unpack
  logic                          cmd_in;
  logic signed [DATA_BITS-1:0]   v_in [3];
  logic [ANGLE_BITS-1:0]         a_in [3];
  always_comb begin
    cmd_in = in_tdata[0];
    for (int k = 0; k < 3; k++) begin
      v_in[k] = in_tdata[1+k*DATA_BITS +: DATA_BITS];
      a_in[k] = in_tdata[1+3*DATA_BITS+k*ANGLE_BITS +: ANGLE_BITS];
    end
  end

  // ---------------- cordic pipeline, stage 0 is the loaded start
  logic                        cv_r   [NIT+1];
  logic                        ccmd_r [NIT+1];
  logic signed [DATA_BITS-1:0] cvec_r [NIT+1][3];
  logic [1:0]                  cq_r   [NIT+1][3];
  logic signed [TW-1:0]        cx_r   [NIT+1][3];
  logic signed [TW-1:0]        cy_r   [NIT+1][3];
  logic signed [TW-1:0]        cz_r   [NIT+1][3];

  always_ff @(posedge clk) begin
    if (!rst_n) cv_r[0] <= 1'b0;
    else if (adv) cv_r[0] <= in_tvalid;
    if (adv) begin
      ccmd_r[0] <= cmd_in;
      for (int k = 0; k < 3; k++) begin
        logic [31:0] a32;
        a32 = 32'(a_in[k]) << (32 - ANGLE_BITS);
        cvec_r[0][k] <= v_in[k];
        cq_r[0][k]   <= a32[31:30];
        cx_r[0][k]   <= CORDIC_K;
        cy_r[0][k]   <= '0;
        cz_r[0][k]   <= TW'(a32[29:0]);
      end
    end
  end

  for (genvar i = 0; i < NIT; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (!rst_n) cv_r[i+1] <= 1'b0;
      else if (adv) cv_r[i+1] <= cv_r[i];
      if (adv) begin
        ccmd_r[i+1] <= ccmd_r[i];
        for (int k = 0; k < 3; k++) begin
          cvec_r[i+1][k] <= cvec_r[i][k];
          cq_r[i+1][k]   <= cq_r[i][k];
          if (!cz_r[i][k][TW-1]) begin
            cx_r[i+1][k] <= cx_r[i][k] - (cy_r[i][k] >>> i);
            cy_r[i+1][k] <= cy_r[i][k] + (cx_r[i][k] >>> i);
            cz_r[i+1][k] <= cz_r[i][k] - atan_turn(i);
          end else begin
            cx_r[i+1][k] <= cx_r[i][k] + (cy_r[i][k] >>> i);
            cy_r[i+1][k] <= cy_r[i][k] - (cx_r[i][k] >>> i);
            cz_r[i+1][k] <= cz_r[i][k] + atan_turn(i);
          end
        end
      end
    end
  end

  // ---------------- quadrant map -> cos/sin (p, y, r)
  logic                        s1v_r, s1cmd_r;
  logic signed [DATA_BITS-1:0] s1vec_r [3];
  logic signed [QW-1:0]        c_r [3], s_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) s1v_r <= 1'b0;
    else if (adv) s1v_r <= cv_r[NIT];
    if (adv) begin
      s1cmd_r <= ccmd_r[NIT];
      for (int k = 0; k < 3; k++) begin
        logic signed [QW-1:0] x, y;
        x = QW'(cx_r[NIT][k]);
        y = QW'(cy_r[NIT][k]);
        s1vec_r[k] <= cvec_r[NIT][k];
        case (cq_r[NIT][k])
          2'd0: begin c_r[k] <= x;  s_r[k] <= y;  end
          2'd1: begin c_r[k] <= -y; s_r[k] <= x;  end
          2'd2: begin c_r[k] <= -x; s_r[k] <= -y; end
          default: begin c_r[k] <= y; s_r[k] <= -x; end
        endcase
      end
    end
  end

  // ---------------- first products
  logic                        s2v_r, s2cmd_r;
  logic signed [DATA_BITS-1:0] s2vec_r [3];
  logic signed [QW-1:0] cp2_r, sp2_r, sy2_r;
  logic signed [QW-1:0] crsy_r, srsy_r, m0_r, m2_r, m4_r, m7_r, srsp_r, srcp_r, crsp_r,
                        crcp_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s2v_r <= 1'b0;
    else if (adv) s2v_r <= s1v_r;
    if (adv) begin
      s2cmd_r <= s1cmd_r;
      s2vec_r <= s1vec_r;
      cp2_r <= c_r[0]; sp2_r <= s_r[0]; sy2_r <= s_r[1];
      crsy_r <= mulq(c_r[2], s_r[1]);
      srsy_r <= mulq(s_r[2], s_r[1]);
      m0_r   <= mulq(c_r[1], c_r[0]);
      m2_r   <= -mulq(c_r[1], s_r[0]);
      m4_r   <= mulq(c_r[2], c_r[1]);
      m7_r   <= -mulq(s_r[2], c_r[1]);
      srsp_r <= mulq(s_r[2], s_r[0]);
      srcp_r <= mulq(s_r[2], c_r[0]);
      crsp_r <= mulq(c_r[2], s_r[0]);
      crcp_r <= mulq(c_r[2], c_r[0]);
    end
  end

  // ---------------- matrix
  logic                        s3v_r, s3cmd_r;
  logic signed [DATA_BITS-1:0] s3vec_r [3];
  logic signed [QW-1:0]        m_r [9];
  always_ff @(posedge clk) begin
    if (!rst_n) s3v_r <= 1'b0;
    else if (adv) s3v_r <= s2v_r;
    if (adv) begin
      s3cmd_r <= s2cmd_r;
      s3vec_r <= s2vec_r;
      m_r[0] <= m0_r;
      m_r[1] <= sy2_r;
      m_r[2] <= m2_r;
      m_r[3] <= srsp_r - mulq(crsy_r, cp2_r);
      m_r[4] <= m4_r;
      m_r[5] <= srcp_r + mulq(crsy_r, sp2_r);
      m_r[6] <= crsp_r + mulq(srsy_r, cp2_r);
      m_r[7] <= m7_r;
      m_r[8] <= crcp_r - mulq(srsy_r, sp2_r);
    end
  end

  // ---------------- nine products
  logic                 s4v_r;
  logic signed [PW-1:0] p_r [3][3];
  always_ff @(posedge clk) begin
    if (!rst_n) s4v_r <= 1'b0;
    else if (adv) s4v_r <= s3v_r;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p_r[i][j] <= PW'((s3cmd_r ? m_r[j*3+i] : m_r[i*3+j]) * s3vec_r[j]);
        end
      end
    end
  end

  // ---------------- sum, round, saturate
  logic                 s5v_r;
  logic [OW-1:0]        s5d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s5v_r <= 1'b0;
    else if (adv) s5v_r <= s4v_r;
    if (adv) begin
      logic [OW-1:0] d;
      d = '0;
      for (int i = 0; i < 3; i++) begin
        logic signed [SW-1:0] sum, sh;
        sum = SW'(p_r[i][0]) + SW'(p_r[i][1]) + SW'(p_r[i][2]) + SW'(64'sd536870912);
        sh  = sum >>> 30;
        if (sh > SAT_MAX)
          d[i*DATA_BITS +: DATA_BITS] = SAT_MAX[DATA_BITS-1:0];
        else if (sh < SAT_MIN)
          d[i*DATA_BITS +: DATA_BITS] = SAT_MIN[DATA_BITS-1:0];
        else
          d[i*DATA_BITS +: DATA_BITS] = sh[DATA_BITS-1:0];
      end
      s5d_r <= d;
    end
  end

  assign out_tvalid = s5v_r;
  assign out_tdata  = s5d_r;

  // ---------------- checks
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("not ready with empty output");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && s4v_r |=> out_tvalid)
    else $error("beat lost in last stage");

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the euler angle vector rotation unit: every input
// beat is run through a local fixed-point rotation predictor, and output beats
// are compared in order under random sender gaps, receiver stalls and a long
// receiver hold-off that backs the pipeline up into the input side
// ----------------------------------------------------------------------------
module tb_top;
  import eavr_pkg::*;

  localparam int IN_W  = ((1 + 3*DATA_BITS_DEF + 3*ANGLE_BITS_DEF + 7) / 8) * 8;
  localparam int OUT_W = ((3*DATA_BITS_DEF + 7) / 8) * 8;
  localparam int DRAIN = TRIG_ITER_DEF + 20;
  localparam logic CMD_TO_BODY     = 1'b0;
  localparam logic CMD_TO_INERTIAL = 1'b1;
  localparam longint ATAN_LUT [24] = '{
    536870912, 316933406, 167458907, 85268948, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  typedef struct {
    logic                     cmd;
    logic signed [31:0]       vx, vy, vz;
    logic [ANGLE_BITS_DEF-1:0] pitch, yaw, roll;
  } rot_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  logic [OUT_W-1:0] rotated_q [$];
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int mismatches = 0;
  int beats_in = 0;
  int beats_out = 0;

  euler_angle_vector_rotation_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    // command, vec_x, vec_y, vec_z, pitch_angle, yaw_angle, roll_angle
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    // out_x, out_y, out_z
    .out_tdata (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

  function automatic void turn_sincos(input logic [ANGLE_BITS_DEF-1:0] ang,
                                      output longint c, output longint s);
    logic [31:0] a32;
    longint x, y, z, dx, dy;
    a32 = {ang, {(32-ANGLE_BITS_DEF){1'b0}}};
    x = 652032874;
    y = 0;
    z = longint'(a32[29:0]);
    for (int i = 0; i < TRIG_ITER_DEF && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ATAN_LUT[i];
      end else begin
        x = x + dx; y = y - dy; z = z + ATAN_LUT[i];
      end
    end
    case (a32[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint q30_mul(input longint a, input longint b);
    longint p;
    p = a * b + (64'sd1 <<< 29);
    return p >>> 30;
  endfunction

  function automatic logic signed [31:0] row_dot(input longint c0, input longint c1,
                                                 input longint c2, input rot_item_t it);
    logic signed [127:0] acc, a0, a1, a2, b0, b1, b2;
    a0 = c0; a1 = c1; a2 = c2;
    b0 = it.vx; b1 = it.vy; b2 = it.vz;
    acc = a0 * b0 + a1 * b1 + a2 * b2;
    acc = (acc + (128'sd1 <<< 29)) >>> 30;
    if (acc > 128'sd2147483647) return 32'sh7fffffff;
    if (acc < -128'sd2147483648) return 32'sh80000000;
    return acc[31:0];
  endfunction

  function automatic logic [OUT_W-1:0] rotate_vector(input rot_item_t it);
    longint cp, sp, cy, sy, cr, sr, crsy, srsy;
    longint m [9];
    logic signed [31:0] r [3];
    turn_sincos(it.pitch, cp, sp);
    turn_sincos(it.yaw, cy, sy);
    turn_sincos(it.roll, cr, sr);
    crsy = q30_mul(cr, sy);
    srsy = q30_mul(sr, sy);
    m[0] = q30_mul(cy, cp);
    m[1] = sy;
    m[2] = -q30_mul(cy, sp);
    m[3] = q30_mul(sr, sp) - q30_mul(crsy, cp);
    m[4] = q30_mul(cr, cy);
    m[5] = q30_mul(sr, cp) + q30_mul(crsy, sp);
    m[6] = q30_mul(cr, sp) + q30_mul(srsy, cp);
    m[7] = -q30_mul(sr, cy);
    m[8] = q30_mul(cr, cp) - q30_mul(srsy, sp);
    for (int i = 0; i < 3; i++) begin
      if (it.cmd == CMD_TO_INERTIAL)
        r[i] = row_dot(m[i], m[3+i], m[6+i], it);
      else
        r[i] = row_dot(m[3*i], m[3*i+1], m[3*i+2], it);
    end
    return OUT_W'({r[2], r[1], r[0]});
  endfunction

  task automatic send_beat(input rot_item_t it);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({it.roll, it.yaw, it.pitch, it.vz, it.vy, it.vx, it.cmd});
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    rotated_q.push_back(rotate_vector(it));
    beats_in++;
  endtask

  function automatic logic [31:0] pick_vec();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ANGLE_BITS_DEF-1:0] pick_angle();
    case ($urandom_range(0, 7))
      0: return ANGLE_BITS_DEF'($urandom_range(0, 3)) << (ANGLE_BITS_DEF - 2);
      1: return (ANGLE_BITS_DEF'($urandom_range(0, 3)) << (ANGLE_BITS_DEF - 2))
                + ANGLE_BITS_DEF'($urandom_range(0, 2)) - 1'b1;
      default: return ANGLE_BITS_DEF'($urandom);
    endcase
  endfunction

  function automatic rot_item_t random_item();
    rot_item_t it;
    it.cmd   = 1'($urandom_range(0, 1));
    it.vx    = pick_vec();
    it.vy    = pick_vec();
    it.vz    = pick_vec();
    it.pitch = pick_angle();
    it.yaw   = pick_angle();
    it.roll  = pick_angle();
    return it;
  endfunction

  task automatic send_rot(input logic c, input logic [31:0] x, input logic [31:0] y,
                          input logic [31:0] z, input logic [15:0] p,
                          input logic [15:0] w, input logic [15:0] r);
    rot_item_t it;
    it = '{c, x, y, z, p, w, r};
    send_beat(it);
  endtask

  task automatic wait_drained();
    while (rotated_q.size() != 0) @(posedge clk);
  endtask

  // receiver side: random stalls, or a counted hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // output beat is taken at the next rising edge
  always @(negedge clk) begin
    logic [OUT_W-1:0] exp_v;
    if (rst_n && out_tvalid && out_tready) begin
      beats_out++;
      if (rotated_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat %h", out_tdata);
      end else begin
        exp_v = rotated_q.pop_front();
        for (int k = 0; k < 3; k++) begin
          if (out_tdata[32*k +: 32] !== exp_v[32*k +: 32]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("beat %0d component %0d: expected %h got %h", beats_out, k,
                       exp_v[32*k +: 32], out_tdata[32*k +: 32]);
          end
        end
      end
    end
  end

  task automatic test_directed();
    logic [31:0] vmax, vmin;
    vmax = 32'h7fffffff;
    vmin = 32'h80000000;
    sender_idle_pct = 0; stall_pct = 0;
    send_rot(CMD_TO_BODY,     32'h10000, 32'h20000, 32'h30000, 16'h0, 16'h0, 16'h0);
    send_rot(CMD_TO_INERTIAL, 32'h10000, 32'h20000, 32'h30000, 16'h0, 16'h0, 16'h0);
    send_rot(CMD_TO_BODY,     32'h10000, 32'h0, 32'h0, 16'h4000, 16'h0, 16'h0);
    send_rot(CMD_TO_BODY,     32'h10000, 32'h0, 32'h0, 16'h0, 16'h8000, 16'h0);
    send_rot(CMD_TO_BODY,     32'h0, 32'h10000, 32'h0, 16'h0, 16'h0, 16'hc000);
    send_rot(CMD_TO_INERTIAL, 32'h0, 32'h0, 32'h10000, 16'hffff, 16'hffff, 16'hffff);
    send_rot(CMD_TO_BODY,     vmax, vmax, vmax, 16'h2000, 16'h2000, 16'h2000);
    send_rot(CMD_TO_INERTIAL, vmax, vmax, vmax, 16'h2000, 16'h2000, 16'h2000);
    send_rot(CMD_TO_BODY,     vmin, vmin, vmin, 16'h2000, 16'h2000, 16'h2000);
    send_rot(CMD_TO_INERTIAL, vmin, vmax, vmin, 16'he000, 16'h6000, 16'ha000);
    send_rot(CMD_TO_BODY,     vmax, vmin, vmax, 16'h1234, 16'h8765, 16'hfedc);
    send_rot(CMD_TO_BODY,     32'h0, 32'h0, 32'h0, 16'h3fff, 16'h7fff, 16'hbfff);
    send_rot(CMD_TO_INERTIAL, 32'hffffffff, 32'h1, 32'hffff0000, 16'h4001, 16'h8001,
             16'hc001);
    send_rot(CMD_TO_BODY,     vmax, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0);
    send_rot(CMD_TO_BODY,     vmin, vmin, 32'h0, 16'h8000, 16'h8000, 16'h8000);
    send_rot(CMD_TO_INERTIAL, 32'h55555555, 32'haaaaaaaa, 32'h5a5a5a5a, 16'haaaa,
             16'h5555, 16'h0001);
    in_tvalid <= 1'b0;
    wait_drained();
  endtask

  task automatic test_random(input int n, input int idle, input int stall);
    sender_idle_pct = idle;
    stall_pct = stall;
    repeat (n) send_beat(random_item());
    in_tvalid <= 1'b0;
    wait_drained();
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_cycles <= 150;
    repeat (80) send_beat(random_item());
    in_tvalid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(200, 0, 0);
    test_random(200, 62, 0);
    test_random(200, 0, 62);
    test_random(200, 33, 33);
    test_backpressure();
    repeat (DRAIN) @(posedge clk);
    $display("%0d beats in, %0d beats out: directed angles and extremes,", beats_in,
             beats_out);
    $display("random vectors in both directions under gaps, stalls and a long hold-off");
    if (mismatches == 0 && rotated_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/eavr_pkg.sv
sv/euler_angle_vector_rotation_unit.sv
tb/sv/tb_top.sv
